// ----- sv/rcc_pkg.sv -----
// Shared constants and types for the rounded corner circle contact unit.
package rcc_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_CORNER_X      = 3'd0,
        CFG_CORNER_Y      = 3'd1,
        CFG_CORNER_RADIUS = 3'd2,
        CFG_OPENS_POS_X   = 3'd3,
        CFG_OPENS_POS_Y   = 3'd4
    } cfg_idx_t;

    localparam int DistW     = 33;             // floor(sqrt) of a 66-bit square sum
    localparam int SqSumW    = 66;
    localparam int SqRemW    = 68;             // root remainder, headroom for trial term
    localparam int SqStages  = DistW;          // one root bit per stage
    localparam int NumW      = 64;             // dividend width
    localparam int DivRemW   = 65;
    localparam int QuotW     = 32;
    localparam int DivStages = QuotW;          // one quotient bit per stage
    localparam int NormShift = 14;             // Q2.14 normals
    localparam int NumDiv    = 4;              // contact x/y, normal x/y

    localparam int DIV_CX = 0;
    localparam int DIV_CY = 1;
    localparam int DIV_NX = 2;
    localparam int DIV_NY = 3;

    // side data carried along the root stages
    typedef struct packed {
        logic                ok;
        logic                sx;
        logic                sy;
        logic signed [31:0]  inner;
        logic [DistW-1:0]    adx;
        logic [DistW-1:0]    ady;
        logic [NumW-1:0]     px;
        logic [NumW-1:0]     py;
        logic [31:0]         z;
        logic [15:0]         id;
    } sq_side_t;

    // side data carried along the divider stages
    typedef struct packed {
        logic                ok;
        logic                sx;
        logic                sy;
        logic signed [31:0]  inner;
        logic [DistW-1:0]    dlen;
        logic [31:0]         z;
        logic [15:0]         id;
    } div_side_t;

endpackage

// ----- sv/rounded_corner_circle_contact_unit.sv -----
// Top level: pipelined circle versus concave corner arc contact test.
// Registers from accept to result: stage A, stage B, stage C, 33 root stages, divider prep, 32 divider stages, output.
// Throughput: one item per cycle; a stall at the output freezes the whole pipeline.
// The 33 root stages and 32 divider stages each resolve one bit with a compare-subtract.
// Reset (rst_n low, async) clears all stage valid bits and the configuration registers to zero.
// cfg_ready is always high; registers may only be written while the pipeline is empty.
module rounded_corner_circle_contact_unit (
    input  logic               clk,
    input  logic               rst_n,
    // config write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    // input items
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] other_x,
    input  logic signed [31:0] other_y,
    input  logic signed [31:0] other_z,
    input  logic [30:0]        other_radius,
    input  logic [15:0]        other_id,
    // result items
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    output logic signed [31:0] contact_x,
    output logic signed [31:0] contact_y,
    output logic signed [31:0] contact_z,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic [30:0]        depth,
    output logic [15:0]        body_id
);

    localparam int SQS = rcc_pkg::SqStages;
    localparam int DVS = rcc_pkg::DivStages;

    // ---------------- configuration registers ----------------
    logic signed [31:0] corner_x_reg;
    logic signed [31:0] corner_y_reg;
    logic [30:0]        corner_radius_reg;
    logic               opens_pos_x_reg;
    logic               opens_pos_y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_x_reg      <= '0;
            corner_y_reg      <= '0;
            corner_radius_reg <= '0;
            opens_pos_x_reg   <= 1'b0;
            opens_pos_y_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rcc_pkg::CFG_CORNER_X:      corner_x_reg      <= cfg_data;
                rcc_pkg::CFG_CORNER_Y:      corner_y_reg      <= cfg_data;
                rcc_pkg::CFG_CORNER_RADIUS: corner_radius_reg <= cfg_data[30:0];
                rcc_pkg::CFG_OPENS_POS_X:   opens_pos_x_reg   <= cfg_data[0];
                rcc_pkg::CFG_OPENS_POS_Y:   opens_pos_y_reg   <= cfg_data[0];
                default: ;  // unknown index ignored
            endcase
        end
    end

    // ---------------- pipeline enable ----------------
    // Global advance: everything moves unless a finished result is held.
    logic en;
    logic out_valid_reg;
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // ---------------- stage A: offsets, signs, quadrant ----------------
    logic signed [32:0] dx, dy;
    logic signed [31:0] inner;
    logic               quad_ok;

    always_comb
    begin
        dx = {other_x[31], other_x} - {corner_x_reg[31], corner_x_reg};
        dy = {other_y[31], other_y} - {corner_y_reg[31], corner_y_reg};
        inner = $signed({1'b0, corner_radius_reg}) - $signed({1'b0, other_radius});
        quad_ok = ((!dx[32] && (dx != '0)) == opens_pos_x_reg) &&
                  ((!dy[32] && (dy != '0)) == opens_pos_y_reg);
    end

    logic               a_valid_reg;
    logic               a_ok_reg, a_sx_reg, a_sy_reg;
    logic [32:0]        a_adx_reg, a_ady_reg;
    logic [30:0]        a_ainner_reg;
    logic signed [31:0] a_inner_reg;
    logic [31:0]        a_z_reg;
    logic [15:0]        a_id_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ok_reg     <= quad_ok;
            a_sx_reg     <= dx[32];
            a_sy_reg     <= dy[32];
            a_adx_reg    <= dx[32] ? 33'(-dx) : 33'(dx);
            a_ady_reg    <= dy[32] ? 33'(-dy) : 33'(dy);
            a_ainner_reg <= inner[31] ? 31'(-inner) : inner[30:0];
            a_inner_reg  <= inner;
            a_z_reg      <= other_z;
            a_id_reg     <= other_id;
        end
    end

    // ---------------- stage B: products ----------------
    // |d| <= 2^32, so the top bit is set only when the low 32 bits are zero.
    logic [64:0]        b_sqx_reg, b_sqy_reg;
    logic [61:0]        b_sqi_reg;
    logic               b_valid_reg;
    rcc_pkg::sq_side_t  b_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (en)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_sqx_reg <= a_adx_reg[32] ? {1'b1, 64'd0} :
                         {1'b0, 64'(a_adx_reg[31:0]) * 64'(a_adx_reg[31:0])};
            b_sqy_reg <= a_ady_reg[32] ? {1'b1, 64'd0} :
                         {1'b0, 64'(a_ady_reg[31:0]) * 64'(a_ady_reg[31:0])};
            b_sqi_reg <= 62'(a_ainner_reg) * 62'(a_ainner_reg);
            b_side_reg.ok    <= a_ok_reg;
            b_side_reg.sx    <= a_sx_reg;
            b_side_reg.sy    <= a_sy_reg;
            b_side_reg.inner <= a_inner_reg;
            b_side_reg.adx   <= a_adx_reg;
            b_side_reg.ady   <= a_ady_reg;
            b_side_reg.px    <= a_adx_reg[32] ? {1'b0, corner_radius_reg, 32'd0} :
                                64'(corner_radius_reg) * 64'(a_adx_reg[31:0]);
            b_side_reg.py    <= a_ady_reg[32] ? {1'b0, corner_radius_reg, 32'd0} :
                                64'(corner_radius_reg) * 64'(a_ady_reg[31:0]);
            b_side_reg.z     <= a_z_reg;
            b_side_reg.id    <= a_id_reg;
        end
    end

    // ---------------- stage C + root stages ----------------
    logic [rcc_pkg::SqRemW-1:0] sq_rem_reg  [0:SQS];
    logic [rcc_pkg::DistW-1:0]  sq_root_reg [0:SQS];
    rcc_pkg::sq_side_t          sq_side_reg [0:SQS];
    logic                       sq_valid_reg[0:SQS];
    logic [rcc_pkg::SqSumW-1:0] dsq;
    rcc_pkg::sq_side_t          sq_side_in;

    assign dsq = rcc_pkg::SqSumW'(b_sqx_reg) + rcc_pkg::SqSumW'(b_sqy_reg);

    always_comb
    begin
        sq_side_in    = b_side_reg;
        // too close: inner radius squared above the distance squared
        sq_side_in.ok = b_side_reg.ok && (rcc_pkg::SqSumW'(b_sqi_reg) <= dsq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_valid_reg[0] <= 1'b0;
        else if (en)
            sq_valid_reg[0] <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_rem_reg[0]     <= rcc_pkg::SqRemW'(dsq);
            sq_root_reg[0]    <= '0;
            sq_side_reg[0]    <= sq_side_in;
        end
    end

    for (genvar i = 0; i < SQS; i++)
    begin : g_sqrt
        localparam int B = SQS - 1 - i;
        logic [rcc_pkg::SqRemW-1:0] trial;
        assign trial = (rcc_pkg::SqRemW'(sq_root_reg[i]) << (B + 1)) +
                       (rcc_pkg::SqRemW'(1) << (2 * B));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_valid_reg[i+1] <= 1'b0;
            else if (en)
                sq_valid_reg[i+1] <= sq_valid_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_side_reg[i+1] <= sq_side_reg[i];
                if (trial <= sq_rem_reg[i])
                begin
                    sq_rem_reg[i+1]  <= sq_rem_reg[i] - trial;
                    sq_root_reg[i+1] <= sq_root_reg[i] | (rcc_pkg::DistW'(1) << B);
                end
                else
                begin
                    sq_rem_reg[i+1]  <= sq_rem_reg[i];
                    sq_root_reg[i+1] <= sq_root_reg[i];
                end
            end
        end
    end

    // ---------------- divider prep + divider stages ----------------
    logic [rcc_pkg::DistW-1:0]   dlen;
    logic [rcc_pkg::NumW-1:0]    half;
    rcc_pkg::sq_side_t           ss;
    assign dlen = sq_root_reg[SQS];
    assign ss   = sq_side_reg[SQS];
    assign half = rcc_pkg::NumW'(dlen >> 1);

    logic [rcc_pkg::DivRemW-1:0] dv_rem_reg [0:DVS][rcc_pkg::NumDiv];
    logic [rcc_pkg::QuotW-1:0]   dv_q_reg   [0:DVS][rcc_pkg::NumDiv];
    rcc_pkg::div_side_t          dv_side_reg[0:DVS];
    logic                        dv_valid_reg[0:DVS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else if (en)
            dv_valid_reg[0] <= sq_valid_reg[SQS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // round half up: add half the divisor to the dividend
            dv_rem_reg[0][rcc_pkg::DIV_CX] <= rcc_pkg::DivRemW'(ss.px + half);
            dv_rem_reg[0][rcc_pkg::DIV_CY] <= rcc_pkg::DivRemW'(ss.py + half);
            dv_rem_reg[0][rcc_pkg::DIV_NX] <=
                rcc_pkg::DivRemW'((rcc_pkg::NumW'(ss.adx) << rcc_pkg::NormShift) + half);
            dv_rem_reg[0][rcc_pkg::DIV_NY] <=
                rcc_pkg::DivRemW'((rcc_pkg::NumW'(ss.ady) << rcc_pkg::NormShift) + half);
            for (int k = 0; k < rcc_pkg::NumDiv; k++)
                dv_q_reg[0][k] <= '0;
            dv_side_reg[0].ok    <= ss.ok && (dlen != '0);
            dv_side_reg[0].sx    <= ss.sx;
            dv_side_reg[0].sy    <= ss.sy;
            dv_side_reg[0].inner <= ss.inner;
            dv_side_reg[0].dlen  <= dlen;
            dv_side_reg[0].z     <= ss.z;
            dv_side_reg[0].id    <= ss.id;
        end
    end

    for (genvar j = 0; j < DVS; j++)
    begin : g_div
        localparam int B = DVS - 1 - j;
        logic [rcc_pkg::DivRemW-1:0] dsh;
        assign dsh = rcc_pkg::DivRemW'(dv_side_reg[j].dlen) << B;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[j+1] <= 1'b0;
            else if (en)
                dv_valid_reg[j+1] <= dv_valid_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_side_reg[j+1] <= dv_side_reg[j];
                for (int k = 0; k < rcc_pkg::NumDiv; k++)
                begin
                    if (dv_rem_reg[j][k] >= dsh)
                    begin
                        dv_rem_reg[j+1][k] <= dv_rem_reg[j][k] - dsh;
                        dv_q_reg[j+1][k]   <= dv_q_reg[j][k] | (rcc_pkg::QuotW'(1) << B);
                    end
                    else
                    begin
                        dv_rem_reg[j+1][k] <= dv_rem_reg[j][k];
                        dv_q_reg[j+1][k]   <= dv_q_reg[j][k];
                    end
                end
            end
        end
    end

    // ---------------- output stage: signs, offsets, saturation ----------------
    rcc_pkg::div_side_t  ds;
    logic signed [33:0]  cx_sum, cy_sum;
    logic signed [33:0]  qx_s, qy_s;
    logic signed [34:0]  dep;
    logic signed [31:0]  cx_sat, cy_sat;
    logic [30:0]         dep_sat;
    logic [15:0]         nx, ny;

    assign ds = dv_side_reg[DVS];

    always_comb
    begin
        qx_s = $signed({2'b00, dv_q_reg[DVS][rcc_pkg::DIV_CX]});
        qy_s = $signed({2'b00, dv_q_reg[DVS][rcc_pkg::DIV_CY]});
        if (ds.sx)
            qx_s = -qx_s;
        if (ds.sy)
            qy_s = -qy_s;
        cx_sum = $signed({{2{corner_x_reg[31]}}, corner_x_reg}) + qx_s;
        cy_sum = $signed({{2{corner_y_reg[31]}}, corner_y_reg}) + qy_s;

        if (cx_sum > 34'sh0_7FFF_FFFF)
            cx_sat = 32'sh7FFF_FFFF;
        else if (cx_sum < -34'sh0_8000_0000)
            cx_sat = 32'sh8000_0000;
        else
            cx_sat = cx_sum[31:0];

        if (cy_sum > 34'sh0_7FFF_FFFF)
            cy_sat = 32'sh7FFF_FFFF;
        else if (cy_sum < -34'sh0_8000_0000)
            cy_sat = 32'sh8000_0000;
        else
            cy_sat = cy_sum[31:0];

        nx = dv_q_reg[DVS][rcc_pkg::DIV_NX][15:0];
        ny = dv_q_reg[DVS][rcc_pkg::DIV_NY][15:0];
        if (ds.sx)
            nx = -nx;
        if (ds.sy)
            ny = -ny;

        dep = $signed({2'b00, ds.dlen}) - $signed({{3{ds.inner[31]}}, ds.inner});
        if (dep < 0)
            dep_sat = '0;
        else if (dep > 35'sh0_7FFF_FFFF)
            dep_sat = 31'h7FFF_FFFF;
        else
            dep_sat = dep[30:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_valid_reg[DVS];
    end

    // no hit: every field reads zero
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit       <= ds.ok;
            contact_x <= ds.ok ? cx_sat : '0;
            contact_y <= ds.ok ? cy_sat : '0;
            contact_z <= ds.ok ? ds.z : '0;
            normal_x  <= ds.ok ? nx : '0;
            normal_y  <= ds.ok ? ny : '0;
            depth     <= ds.ok ? dep_sat : '0;
            body_id   <= ds.ok ? ds.id : '0;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    // a miss carries zero contact x/y, depth, normals and body id
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (contact_x == 0 && contact_y == 0 && depth == 0 &&
                                 normal_x == 0 && normal_y == 0 && body_id == 0))
        else $error("miss result with nonzero fields");

    // each normal component stays within plus or minus one (16384)
    a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hit) |-> (normal_x >= -16'sd16384 && normal_x <= 16'sd16384 &&
                                normal_y >= -16'sd16384 && normal_y <= 16'sd16384))
        else $error("normal component out of range");

    // a held result freezes the last divider stage too
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(dv_valid_reg[DVS]))
        else $error("pipeline moved during output stall");
`endif

endmodule

// ----- verif/tb_rounded_corner_circle_contact_unit.sv -----
// Testbench for the rounded corner circle contact unit: predictor, driver, monitor, checks.
module tb_rounded_corner_circle_contact_unit;

    // one circle query as driven on the input ports
    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [30:0]        rad;
        logic [15:0]        id;
    } query_t;

    // one contact result as seen on the output ports
    typedef struct {
        logic               hit;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic [30:0]        depth;
        logic [15:0]        id;
    } contact_t;

    localparam int IdleLimit = 4000;   // well above the pipeline latency plus stalls
    localparam int DrainWait = 100;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic signed [31:0] other_x;
    logic signed [31:0] other_y;
    logic signed [31:0] other_z;
    logic [30:0] other_radius;
    logic [15:0] other_id;
    logic out_valid;
    logic out_stall;
    logic hit;
    logic signed [31:0] contact_x;
    logic signed [31:0] contact_y;
    logic signed [31:0] contact_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic [30:0] depth;
    logic [15:0] body_id;

    rounded_corner_circle_contact_unit DUT (.*);

    // predictor's copy of the corner registers
    logic signed [31:0] arc_cx;
    logic signed [31:0] arc_cy;
    logic [30:0]        arc_r;
    logic               arc_px;
    logic               arc_py;

    query_t   pending_queries[$];
    contact_t expected_contacts[$];
    int       fail_count;
    int       idle_cycles;
    bit       drive_done;
    bit       in_taken;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // bit-exact floor(sqrt) of a 66-bit sum
    function automatic logic [33:0] isqrt66(logic [65:0] n);
        logic [33:0] r;
        logic [33:0] c;
        r = '0;
        for (int b = 33; b >= 0; b--)
        begin
            c = r | (34'd1 << b);
            if ({34'd0, c} * {34'd0, c} <= {2'b0, n})
                r = c;
        end
        return r;
    endfunction

    function automatic logic [63:0] div_near(logic [63:0] num, logic [63:0] den);
        logic [64:0] t;
        t = {1'b0, num} + {1'b0, den >> 1};
        return 64'(t / {1'b0, den});
    endfunction

    function automatic logic signed [31:0] sat_add(logic signed [31:0] base,
                                                   logic [63:0] mag, logic neg);
        logic signed [66:0] v;
        v = neg ? 67'(base) - $signed({3'b0, mag}) : 67'(base) + $signed({3'b0, mag});
        if (v > 67'sd2147483647)
            return 32'sh7fffffff;
        if (v < -67'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic contact_t corner_contact(query_t q);
        contact_t res;
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic signed [33:0] inner;
        logic [33:0] adx;
        logic [33:0] ady;
        logic [33:0] ain;
        logic [65:0] dsq;
        logic [33:0] root_d;
        logic [63:0] m;
        logic signed [34:0] dv;
        res = '{default: '0};
        dx = 34'(q.px) - 34'(arc_cx);
        dy = 34'(q.py) - 34'(arc_cy);
        inner = $signed({3'b0, arc_r}) - $signed({3'b0, q.rad});
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        ain = inner < 0 ? -inner : inner;
        if ((dx > 0) != arc_px || (dy > 0) != arc_py)
            return res;
        dsq = 66'(adx) * 66'(adx) + 66'(ady) * 66'(ady);
        if (66'(ain) * 66'(ain) > dsq)
            return res;
        root_d = isqrt66(dsq);
        if (root_d == 0)
            return res;
        res.hit = 1'b1;
        m = div_near(64'(arc_r) * 64'(adx), 64'(root_d));
        res.cx = sat_add(arc_cx, m, dx < 0);
        m = div_near(64'(arc_r) * 64'(ady), 64'(root_d));
        res.cy = sat_add(arc_cy, m, dy < 0);
        res.cz = q.pz;
        m = div_near(64'(adx) << rcc_pkg::NormShift, 64'(root_d));
        res.nx = dx < 0 ? -16'(m) : 16'(m);
        m = div_near(64'(ady) << rcc_pkg::NormShift, 64'(root_d));
        res.ny = dy < 0 ? -16'(m) : 16'(m);
        dv = $signed({1'b0, root_d}) - 35'(inner);
        if (dv < 0)
            dv = 0;
        if (dv > 35'sd2147483647)
            dv = 35'sd2147483647;
        res.depth = dv[30:0];
        res.id = q.id;
        return res;
    endfunction

    // input handshake as seen at the rising edge
    always @(posedge clk)
    begin
        in_taken <= in_valid && !in_stall;
    end

    // driver: bursts with gaps, payload held while stalled
    int gap_left;
    int burst_left;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_queries.size() > 0)
                begin
                    query_t q;
                    q = pending_queries.pop_front();
                    expected_contacts.push_back(corner_contact(q));
                    other_x <= q.px;
                    other_y <= q.py;
                    other_z <= q.pz;
                    other_radius <= q.rad;
                    other_id <= q.id;
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(30, 0);
                        gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
            // receiver stall pattern: out_stall drawn anew at random on each falling edge
            case ($urandom_range(3, 0))
                0: out_stall <= 1'b1;
                default: out_stall <= ($urandom_range(2, 0) == 0);
            endcase
        end
    end

    // monitor: compare each result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && !out_stall)
            begin
                if (expected_contacts.size() == 0)
                begin
                    $error("result with no prediction waiting");
                    fail_count++;
                end
                else
                begin
                    contact_t e;
                    e = expected_contacts.pop_front();
                    if (hit !== e.hit)
                    begin
                        $error("hit exp %0d got %0d", e.hit, hit);
                        fail_count++;
                    end
                    if (contact_x !== e.cx)
                    begin
                        $error("contact_x exp %0d got %0d", e.cx, contact_x);
                        fail_count++;
                    end
                    if (contact_y !== e.cy)
                    begin
                        $error("contact_y exp %0d got %0d", e.cy, contact_y);
                        fail_count++;
                    end
                    if (contact_z !== e.cz)
                    begin
                        $error("contact_z exp %0d got %0d", e.cz, contact_z);
                        fail_count++;
                    end
                    if (normal_x !== e.nx)
                    begin
                        $error("normal_x exp %0d got %0d", e.nx, normal_x);
                        fail_count++;
                    end
                    if (normal_y !== e.ny)
                    begin
                        $error("normal_y exp %0d got %0d", e.ny, normal_y);
                        fail_count++;
                    end
                    if (depth !== e.depth)
                    begin
                        $error("depth exp %0d got %0d", e.depth, depth);
                        fail_count++;
                    end
                    if (body_id !== e.id)
                    begin
                        $error("body_id exp %0d got %0d", e.id, body_id);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no item accepted at the input or taken at the output
    always @(posedge clk)
    begin
        if (idle_cycles >= IdleLimit)
        begin
            $display("[rounded_corner_circle_contact_unit] ERROR");
            $finish;
        end
    end

    task automatic write_reg(rcc_pkg::cfg_idx_t idx, logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            rcc_pkg::CFG_CORNER_X:      arc_cx = val;
            rcc_pkg::CFG_CORNER_Y:      arc_cy = val;
            rcc_pkg::CFG_CORNER_RADIUS: arc_r = val[30:0];
            rcc_pkg::CFG_OPENS_POS_X:   arc_px = val[0];
            rcc_pkg::CFG_OPENS_POS_Y:   arc_py = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_corner(logic [31:0] x, logic [31:0] y, logic [31:0] r,
                              logic qx, logic qy);
        write_reg(rcc_pkg::CFG_CORNER_X, x);
        write_reg(rcc_pkg::CFG_CORNER_Y, y);
        write_reg(rcc_pkg::CFG_CORNER_RADIUS, r);
        write_reg(rcc_pkg::CFG_OPENS_POS_X, {31'd0, qx});
        write_reg(rcc_pkg::CFG_OPENS_POS_Y, {31'd0, qy});
    endtask

    // drain the pipeline before touching the registers
    task automatic wait_idle();
        while (pending_queries.size() > 0 || expected_contacts.size() > 0 || in_valid)
            @(posedge clk);
        repeat (DrainWait) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word(int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(32'h00400000, 0) - 32'h00200000;
            2: return ($urandom_range(1, 0)) ? 32'h7fffffff - $urandom_range(255, 0)
                                             : 32'h80000000 + $urandom_range(255, 0);
            default: return $urandom_range(32'h000fffff, 0) - 32'h00080000;
        endcase
    endfunction

    // mostly queries near the arc in the open quadrant, some pure noise
    task automatic queue_random(int n);
        query_t q;
        int mode;
        logic [31:0] off;
        for (int i = 0; i < n; i++)
        begin
            mode = $urandom_range(9, 0);
            if (mode < 7)
            begin
                off = $urandom_range(32'h00100000 + arc_r[29:0], 0);
                q.px = arc_cx + (arc_px ? $signed(off) : -$signed(off));
                off = $urandom_range(32'h00100000 + arc_r[29:0], 0);
                q.py = arc_cy + (arc_py ? $signed(off) : -$signed(off));
                if ($urandom_range(7, 0) == 0)
                    q.px = arc_cx;
                q.rad = 31'($urandom_range(arc_r[29:0] + 32'h00010000, 0));
            end
            else
            begin
                q.px = rand_word(mode - 7);
                q.py = rand_word($urandom_range(3, 0));
                q.rad = 31'(rand_word(0));
            end
            q.pz = $urandom();
            q.id = 16'($urandom());
            pending_queries.push_back(q);
        end
    endtask

    initial
    begin
        query_t q;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        other_x = '0;
        other_y = '0;
        other_z = '0;
        other_radius = '0;
        other_id = '0;
        out_stall = 1'b0;
        arc_cx = '0;
        arc_cy = '0;
        arc_r = '0;
        arc_px = 1'b0;
        arc_py = 1'b0;
        fail_count = 0;
        idle_cycles = 0;
        gap_left = 0;
        burst_left = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset registers, zero distance, boundary points
        q = '{px: 0, py: 0, pz: 32'h7fffffff, rad: 0, id: 16'hffff};
        pending_queries.push_back(q);
        q = '{px: -5, py: -7, pz: 32'h80000000, rad: 31'h7fffffff, id: 0};
        pending_queries.push_back(q);
        q = '{px: 32'h80000000, py: 32'h80000000, pz: 1, rad: 0, id: 16'h1234};
        pending_queries.push_back(q);
        q = '{px: 32'h80000000, py: 0, pz: 2, rad: 7, id: 16'h8000};
        pending_queries.push_back(q);
        wait_idle();

        // large positive corner, far outward circles: contact saturation
        set_corner(32'h7fff0000, 32'h7fff0000, 31'h7fffffff, 1'b0, 1'b0);
        q = '{px: 32'h80000000, py: 32'h80000000, pz: 3, rad: 0, id: 1};
        pending_queries.push_back(q);
        q = '{px: 32'h80000000, py: 32'h7fff0000, pz: 4, rad: 31'h7fffffff, id: 2};
        pending_queries.push_back(q);
        q = '{px: 32'h7ffeffff, py: 32'h7ffeffff, pz: 5, rad: 0, id: 3};
        pending_queries.push_back(q);
        q = '{px: 32'h7fff0001, py: 32'h7ffe0000, pz: 6, rad: 0, id: 4};
        pending_queries.push_back(q);
        wait_idle();

        set_corner(32'h80000000, 32'h80000000, 31'h00100000, 1'b1, 1'b1);
        q = '{px: 32'h7fffffff, py: 32'h7fffffff, pz: 7, rad: 31'h7fffffff, id: 5};
        pending_queries.push_back(q);
        q = '{px: 32'h80080000, py: 32'h80000001, pz: 8, rad: 0, id: 6};
        pending_queries.push_back(q);
        q = '{px: 32'h80001000, py: 32'h80001000, pz: 9, rad: 31'h00010000, id: 7};
        pending_queries.push_back(q);
        q = '{px: 32'h800b5050, py: 32'h800b5050, pz: 10, rad: 0, id: 8};
        pending_queries.push_back(q);
        wait_idle();

        // random phases over several corner settings
        for (int ph = 0; ph < 14; ph++)
        begin
            set_corner(rand_word($urandom_range(3, 0)), rand_word($urandom_range(3, 0)),
                       (ph % 5 == 0) ? 32'h7fffffff : $urandom_range(32'h01000000, 0),
                       ph[0], ph[1]);
            queue_random(125);
            wait_idle();
        end

        if (fail_count == 0)
            $display("[rounded_corner_circle_contact_unit] OK");
        else
            $display("[rounded_corner_circle_contact_unit] ERROR");
        $finish;
    end
endmodule

// ----- files.f -----
sv/rcc_pkg.sv
sv/rounded_corner_circle_contact_unit.sv
verif/tb_rounded_corner_circle_contact_unit.sv
